// ----- hw/rtl/tcce_pkg.sv -----
// Shared constants, request codes and store control type of the text console cell engine.
`timescale 1ns / 1ps

package tcce_pkg;

    // Field widths of the item channels and the configuration port.
    localparam int CODE_W      = 21;
    localparam int REQ_TYPE_W  = 3;
    localparam int CELL_ROW_W  = 6;
    localparam int CELL_COL_W  = 7;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 6;
    localparam int COLS_REG_W  = 8;
    localparam int ROWS_REG_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // Width of the scroll epoch stamp kept with each dirty flag.
    localparam int EPOCH_W     = 8;

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LEFT  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_RIGHT = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 3'd4;

    // Control characters with a terminal meaning, and the space.
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 21'h08;
    localparam logic [CODE_W-1:0] CH_TAB       = 21'h09;
    localparam logic [CODE_W-1:0] CH_NEWLINE   = 21'h0A;
    localparam logic [CODE_W-1:0] CH_SPACE     = 21'h20;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_COLS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_ROWS   = 1'b1;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd25;

    // Write controls of the cell store.
    typedef struct packed {
        logic code_we;
        logic flag_we;
        logic flag_val;
    } store_wr_t;

endpackage

// ----- hw/rtl/tcce_ifs.sv -----
// Request and result channel interfaces of the text console cell engine.
`timescale 1ns / 1ps

interface tcce_req_if import tcce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [CODE_W-1:0]     char_code;
    logic                  key_release;
    logic [CELL_ROW_W-1:0] cell_row;
    logic [CELL_COL_W-1:0] cell_col;

    modport source (
        output valid,
        output req_type,
        output char_code,
        output key_release,
        output cell_row,
        output cell_col,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  char_code,
        input  key_release,
        input  cell_row,
        input  cell_col,
        output ready
    );
endinterface

interface tcce_res_if import tcce_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] cursor_col_out;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [ROW_OUT_W-1:0] top_row_out;
    logic [CODE_W-1:0]    cell_code_out;
    logic                 cell_dirty_out;

    modport source (
        output valid,
        output cursor_col_out,
        output cursor_row_out,
        output top_row_out,
        output cell_code_out,
        output cell_dirty_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  cursor_col_out,
        input  cursor_row_out,
        input  top_row_out,
        input  cell_code_out,
        input  cell_dirty_out,
        output ready
    );
endinterface

// ----- hw/rtl/tcce_cell_store.sv -----
// Cell store: code memory and dirty flag memory with scroll epoch stamps.
`timescale 1ns / 1ps

module tcce_cell_store import tcce_pkg::*; #(
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  store_wr_t         wr,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CODE_W-1:0] wcode,
    input  logic [EPOCH_W-1:0] epoch,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CODE_W-1:0] rcode,
    output logic              rdirty
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [CODE_W-1:0] code_mem [DEPTH];
    logic [EPOCH_W:0]  flag_mem [DEPTH];

    logic [CODE_W-1:0] code_rd_reg;
    logic [EPOCH_W:0]  flag_rd_reg;

    // Write port. A flag write stamps the entry with the current epoch.
    always_ff @(posedge clk)
    begin
        if (wr.code_we)
        begin
            code_mem[waddr] <= wcode;
        end
        if (wr.flag_we)
        begin
            flag_mem[waddr] <= {wr.flag_val, epoch};
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            code_rd_reg <= code_mem[raddr];
            flag_rd_reg <= flag_mem[raddr];
        end
    end

    // A cell cleaned before the latest scroll carries an old stamp and reads as dirty.
    assign rcode  = code_rd_reg;
    assign rdirty = flag_rd_reg[EPOCH_W] || (flag_rd_reg[EPOCH_W-1:0] != epoch);

endmodule

// ----- hw/rtl/text_console_cell_engine.sv -----
// Text console cell engine: cursor, top-row ring pointer and cell store sequencer.
// An item is accepted with a cell read, then does its store update and result load for
// reads, cursor moves, plain characters, newline and backspace; a tab adds a print step
// per extra space. A scroll blanks one row of MAX_COLS store entries; the scroll that
// wraps the EPOCH_W-bit epoch sweeps all 2**(row bits + column bits) dirty flags (8192
// default). Clear and reset fill all those entries; no item is accepted until it ends.
`timescale 1ns / 1ps

module text_console_cell_engine import tcce_pkg::*; #(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 64,
    parameter int TAB_SPACES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcce_req_if.sink              req,
    tcce_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_CW = $clog2(MAX_COLS + 1);
    localparam int CNT_RW = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    // Sequencer states.
    localparam logic [2:0] ST_FILL   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_PRINT  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_WRAP   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Physical row of a logical row in the ring.
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0]  top,
        input logic [ROW_W-1:0]  lrow,
        input logic [CNT_RW-1:0] rows
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, lrow};
        if (sum >= (ROW_W + 1)'(rows))
        begin
            sum = sum - (ROW_W + 1)'(rows);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Control registers.
    logic [2:0]            state_reg, state_next;
    logic [COLS_REG_W-1:0] cols_reg, cols_next;
    logic [ROWS_REG_W-1:0] rows_reg, rows_next;
    logic [COL_W-1:0]      cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]      cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]      top_reg, top_next;
    logic [EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [ADDR_W-1:0]     sweep_reg, sweep_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload registers.
    logic [REQ_TYPE_W-1:0] req_type_reg;
    logic [CODE_W-1:0]     char_code_reg;
    logic                  key_rel_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic                  rd_hit_reg;
    logic [TAB_W-1:0]      print_left_reg, print_left_next;
    logic [CODE_W-1:0]     print_code_reg, print_code_next;
    logic [CODE_W-1:0]     rd_code_reg, rd_code_next;
    logic                  rd_dirty_reg, rd_dirty_next;
    logic [COL_OUT_W-1:0]  out_col_reg;
    logic [ROW_OUT_W-1:0]  out_row_reg;
    logic [ROW_OUT_W-1:0]  out_top_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic                  out_dirty_reg;

    // Datapath signals.
    logic [CNT_CW-1:0] cols_eff;
    logic [CNT_RW-1:0] rows_eff;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              finish;
    logic              do_print;
    logic [ROW_W-1:0]  rd_lrow;
    logic [ADDR_W-1:0] rd_addr_in;
    logic              rd_hit_in;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [ROW_W:0]    top_inc;
    logic              nl_scroll;
    logic [ROW_W-1:0]  nl_row;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  adv_row;
    logic              adv_scroll;
    logic [COL_W-1:0]  bk_col;
    logic [ROW_W-1:0]  bk_row;
    logic [ADDR_W-1:0] print_addr;
    logic [ADDR_W-1:0] bs_addr;
    logic [TAB_W-1:0]  step_left;
    logic [CODE_W-1:0] step_code;
    store_wr_t         wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CODE_W-1:0] wr_code;
    logic [CODE_W-1:0] st_code;
    logic              st_dirty;

    // Window size as used, with zero and oversize settings clamped.
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = CNT_CW'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            cols_eff = CNT_CW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNT_CW'(cols_reg);
        end

        if (rows_reg == '0)
        begin
            rows_eff = CNT_RW'(1);
        end
        else if (32'(rows_reg) > MAX_ROWS)
        begin
            rows_eff = CNT_RW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = CNT_RW'(rows_reg);
        end
    end

    assign col_last = COL_W'(cols_eff - 1'b1);
    assign row_last = ROW_W'(rows_eff - 1'b1);

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Cell read address, issued in the accept cycle.
    assign rd_lrow    = ROW_W'(req.cell_row);
    assign rd_addr_in = {phys_row(top_reg, rd_lrow, rows_eff), COL_W'(req.cell_col)};
    assign rd_hit_in  = (32'(req.cell_row) < 32'(rows_eff)) &&
                        (32'(req.cell_col) < 32'(cols_eff));

    // Cursor advance for printing and newline.
    always_comb
    begin
        col_inc   = {1'b0, cur_col_reg} + 1'b1;
        row_inc   = {1'b0, cur_row_reg} + 1'b1;
        top_inc   = {1'b0, top_reg} + 1'b1;
        nl_scroll = (32'(row_inc) >= 32'(rows_eff));
        nl_row    = nl_scroll ? row_last : row_inc[ROW_W-1:0];
        if (32'(col_inc) >= 32'(cols_eff))
        begin
            adv_col    = '0;
            adv_row    = nl_row;
            adv_scroll = nl_scroll;
        end
        else
        begin
            adv_col    = col_inc[COL_W-1:0];
            adv_row    = cur_row_reg;
            adv_scroll = 1'b0;
        end
    end

    // Cursor step back for backspace and cursor left.
    always_comb
    begin
        bk_col = cur_col_reg;
        bk_row = cur_row_reg;
        if (cur_col_reg != '0)
        begin
            bk_col = cur_col_reg - 1'b1;
        end
        else if (cur_row_reg != '0)
        begin
            bk_row = cur_row_reg - 1'b1;
            bk_col = col_last;
        end
    end

    assign print_addr = {phys_row(top_reg, cur_row_reg, rows_eff), cur_col_reg};
    assign bs_addr    = {phys_row(top_reg, bk_row, rows_eff), bk_col};

    // Spaces left and code of the current print step.
    always_comb
    begin
        if (state_reg == ST_PRINT)
        begin
            step_left = print_left_reg;
            step_code = print_code_reg;
        end
        else if (char_code_reg == CH_TAB)
        begin
            step_left = TAB_W'(TAB_SPACES);
            step_code = CH_SPACE;
        end
        else
        begin
            step_left = TAB_W'(1);
            step_code = char_code_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        pend_next       = pend_reg;
        print_left_next = print_left_reg;
        print_code_next = print_code_reg;
        rd_code_next    = rd_code_reg;
        rd_dirty_next   = rd_dirty_reg;
        wr              = '0;
        wr_addr         = print_addr;
        wr_code         = CH_SPACE;
        finish          = 1'b0;
        do_print        = 1'b0;

        unique case (state_reg)
            ST_FILL:
            begin
                // Blank every cell and mark it dirty, one entry per cycle.
                wr.code_we  = 1'b1;
                wr.flag_we  = 1'b1;
                wr.flag_val = 1'b1;
                wr_addr     = sweep_reg;
                sweep_next  = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    if (pend_reg)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rd_code_next  = '0;
                rd_dirty_next = 1'b0;
                unique case (req_type_reg)
                    REQ_PUT:
                    begin
                        if (char_code_reg == CH_NEWLINE)
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = nl_row;
                            print_left_next = '0;
                            if (nl_scroll)
                            begin
                                sweep_next = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        else if (char_code_reg == CH_BACKSPACE)
                        begin
                            cur_col_next = bk_col;
                            cur_row_next = bk_row;
                            wr.code_we   = 1'b1;
                            wr.flag_we   = 1'b1;
                            wr.flag_val  = 1'b1;
                            wr_addr      = bs_addr;
                            finish       = 1'b1;
                        end
                        else
                        begin
                            do_print = 1'b1;
                        end
                    end
                    REQ_READ:
                    begin
                        // Inside the window, return the cell and clear its dirty flag; outside, return zero.
                        if (rd_hit_reg)
                        begin
                            rd_code_next  = st_code;
                            rd_dirty_next = st_dirty;
                            wr.flag_we    = 1'b1;
                            wr.flag_val   = 1'b0;
                            wr_addr       = rd_addr_reg;
                        end
                        finish = 1'b1;
                    end
                    REQ_LEFT:
                    begin
                        if (!key_rel_reg)
                        begin
                            cur_col_next = bk_col;
                            cur_row_next = bk_row;
                        end
                        finish = 1'b1;
                    end
                    REQ_RIGHT:
                    begin
                        if (!key_rel_reg)
                        begin
                            if (cur_col_reg != col_last)
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                            else if (cur_row_reg != row_last)
                            begin
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                        finish = 1'b1;
                    end
                    REQ_CLEAR:
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        top_next     = '0;
                        sweep_next   = '0;
                        state_next   = ST_FILL;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_PRINT:
            begin
                do_print = 1'b1;
            end
            ST_SCROLL:
            begin
                // Blank the old top row across the full store width.
                wr.code_we  = 1'b1;
                wr.flag_we  = 1'b1;
                wr.flag_val = 1'b1;
                wr_addr     = {top_reg, sweep_reg[COL_W-1:0]};
                sweep_next  = sweep_reg + 1'b1;
                if (sweep_reg[COL_W-1:0] == COL_W'(MAX_COLS - 1))
                begin
                    top_next   = (32'(top_inc) >= 32'(rows_eff)) ? '0 : top_inc[ROW_W-1:0];
                    epoch_next = epoch_reg + 1'b1;
                    if (epoch_reg == '1)
                    begin
                        sweep_next = '0;
                        state_next = ST_WRAP;
                    end
                    else if (print_left_reg == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PRINT;
                    end
                end
            end
            ST_WRAP:
            begin
                // Epoch wrapped: force every dirty flag so old stamps cannot match again.
                wr.flag_we  = 1'b1;
                wr.flag_val = 1'b1;
                wr_addr     = sweep_reg;
                sweep_next  = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    if (print_left_reg == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PRINT;
                    end
                end
            end
            ST_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // One print step: write the cell, advance the cursor, scroll past the last row.
        if (do_print)
        begin
            wr.code_we      = 1'b1;
            wr.flag_we      = 1'b1;
            wr.flag_val     = 1'b1;
            wr_addr         = print_addr;
            wr_code         = step_code;
            print_left_next = step_left - 1'b1;
            print_code_next = CH_SPACE;
            cur_col_next    = adv_col;
            cur_row_next    = adv_row;
            if (adv_scroll)
            begin
                sweep_next = '0;
                state_next = ST_SCROLL;
            end
            else if (step_left == TAB_W'(1))
            begin
                finish = 1'b1;
            end
            else
            begin
                state_next = ST_PRINT;
            end
        end

        // Hand the result to the output register, or hold it until the register frees.
        if (finish)
        begin
            if (out_free)
            begin
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end

        // A window setting homes the cursor and the ring pointer.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLS: cols_next = cfg_data[COLS_REG_W-1:0];
                CFG_ROWS: rows_next = cfg_data[ROWS_REG_W-1:0];
            endcase
            cur_col_next = '0;
            cur_row_next = '0;
            top_next     = '0;
        end
    end

    assign out_load = finish && out_free;

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            epoch_reg     <= '0;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request, print and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req.req_type;
            char_code_reg <= req.char_code;
            key_rel_reg   <= req.key_release;
            rd_addr_reg   <= rd_addr_in;
            rd_hit_reg    <= rd_hit_in;
        end
        print_left_reg <= print_left_next;
        print_code_reg <= print_code_next;
        rd_code_reg    <= rd_code_next;
        rd_dirty_reg   <= rd_dirty_next;
        if (out_load)
        begin
            out_col_reg   <= COL_OUT_W'(cur_col_next);
            out_row_reg   <= ROW_OUT_W'(cur_row_next);
            out_top_reg   <= ROW_OUT_W'(top_next);
            out_code_reg  <= rd_code_next;
            out_dirty_reg <= rd_dirty_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.cursor_col_out = out_col_reg;
    assign res.cursor_row_out = out_row_reg;
    assign res.top_row_out    = out_top_reg;
    assign res.cell_code_out  = out_code_reg;
    assign res.cell_dirty_out = out_dirty_reg;

    // Cell store.
    tcce_cell_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk    (clk),
        .wr     (wr),
        .waddr  (wr_addr),
        .wcode  (wr_code),
        .epoch  (epoch_reg),
        .re     (accept),
        .raddr  (rd_addr_in),
        .rcode  (st_code),
        .rdirty (st_dirty)
    );

    // No item is owed while the engine waits for a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("item still pending in idle state");

    // The cursor and ring pointer stay inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_col_reg) < 32'(cols_eff)) && (32'(cur_row_reg) < 32'(rows_eff)) &&
        (32'(top_reg) < 32'(rows_eff)))
        else $error("cursor or top row outside the window");

    // The store is never written in the cycle a cell read is issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(wr.code_we || wr.flag_we))
        else $error("store write in the read issue cycle");

    // The dirty sweep runs only right after the epoch wrapped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRAP) |-> (epoch_reg == '0))
        else $error("dirty sweep without epoch wrap");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the text console cell engine: random traffic and a cell-store predictor.
`timescale 1ns / 1ps

module tb_top;
    import tcce_pkg::*;

    // Geometry of the instance under test (its parameter defaults).
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_SPACES  = 4;
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;

    // Run control.
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 9000;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int REPORT_CAP      = 40;

    // Window settings per random phase, first phase in the low byte.
    // Both window registers see zero, one, their maximum and all ones on the data bus.
    localparam logic [8*NUM_PHASES-1:0] PHASE_COLS = {8'd80, 8'd7, 8'd255, 8'd128, 8'd0, 8'd1};
    localparam logic [8*NUM_PHASES-1:0] PHASE_ROWS = {8'd25, 8'd3, 8'hFF, 8'd64, 8'd0, 8'd1};

    localparam logic [CODE_W:0] BLANK_CELL = {1'b1, CH_SPACE};

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [CODE_W-1:0]     code;
        logic                  key_up;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
    } console_req_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cur_col;
        logic [ROW_OUT_W-1:0] cur_row;
        logic [ROW_OUT_W-1:0] top_row;
        logic [CODE_W-1:0]    code;
        logic                 dirty;
    } console_res_t;

    // Console predictor plus the queue of results it owes the result channel.
    class console_scoreboard;
        logic [CODE_W:0] cells [STORE_CELLS];
        int unsigned     cur_col;
        int unsigned     cur_row;
        int unsigned     top_row;
        int unsigned     cols_reg;
        int unsigned     rows_reg;
        console_res_t    owed_q [$];
        int unsigned     mismatches;
        int unsigned     results_seen;
        int unsigned     scrolls;
        int unsigned     kind_count [8];

        function new();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            cur_col  = 0;
            cur_row  = 0;
            top_row  = 0;
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Out-of-range window registers clamp to 1 or to the store size.
        function int unsigned win_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned win_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        // Logical row is rotated by the top-row pointer to find the physical row.
        function int unsigned cell_index(int unsigned lrow, int unsigned col);
            int unsigned r;
            int unsigned p;
            r = win_rows();
            p = (top_row % r) + (lrow % r);
            if (p >= r) p -= r;
            return (p * MAX_COLS + col % MAX_COLS) % STORE_CELLS;
        endfunction

        // A window write homes the cursor and the ring pointer but keeps the cells.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_COLS) cols_reg = data;
            else rows_reg = data & 8'h7F;
            cur_col = 0;
            cur_row = 0;
            top_row = 0;
        endfunction

        // The freed top row is blanked across the full store width and everything turns dirty.
        function void scroll_up();
            int unsigned base;
            base = (top_row % win_rows()) * MAX_COLS;
            for (int i = 0; i < MAX_COLS; i++) cells[base + i] = BLANK_CELL;
            top_row = (top_row + 1) % win_rows();
            foreach (cells[i]) cells[i][CODE_W] = 1'b1;
            scrolls++;
        endfunction

        function void next_line();
            cur_col = 0;
            cur_row++;
            if (cur_row >= win_rows()) begin
                cur_row = win_rows() - 1;
                scroll_up();
            end
        endfunction

        function void print_code(logic [CODE_W-1:0] code);
            cells[cell_index(cur_row, cur_col)] = {1'b1, code};
            cur_col++;
            if (cur_col >= win_cols()) next_line();
        endfunction

        // Step back one cell, wrapping to the end of the previous line; stays put at the origin.
        function void step_back();
            if (cur_col > 0) begin
                cur_col--;
            end
            else if (cur_row > 0) begin
                cur_row--;
                cur_col = win_cols() - 1;
            end
        endfunction

        // Apply one accepted request and queue the status it must produce.
        function void note_request(console_req_t it);
            console_res_t want;
            int unsigned  a;
            want = '0;
            kind_count[it.kind]++;
            case (it.kind)
                REQ_PUT: begin
                    case (it.code)
                        CH_NEWLINE: next_line();
                        CH_BACKSPACE: begin
                            step_back();
                            cells[cell_index(cur_row, cur_col)] = BLANK_CELL;
                        end
                        CH_TAB: repeat (TAB_SPACES) print_code(CH_SPACE);
                        default: print_code(it.code);
                    endcase
                end
                REQ_READ: begin
                    // Reads outside the window answer zero and leave the dirty mark alone.
                    if (it.row < win_rows() && it.col < win_cols()) begin
                        a = cell_index(it.row, it.col);
                        want.code  = cells[a][CODE_W-1:0];
                        want.dirty = cells[a][CODE_W];
                        cells[a][CODE_W] = 1'b0;
                    end
                end
                REQ_LEFT: begin
                    if (!it.key_up) step_back();
                end
                REQ_RIGHT: begin
                    if (!it.key_up) begin
                        if (cur_col < win_cols() - 1) begin
                            cur_col++;
                        end
                        else if (cur_row < win_rows() - 1) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                end
                REQ_CLEAR: begin
                    foreach (cells[i]) cells[i] = BLANK_CELL;
                    top_row = 0;
                    cur_col = 0;
                    cur_row = 0;
                end
                default: begin
                end
            endcase
            want.cur_col = COL_OUT_W'(cur_col);
            want.cur_row = ROW_OUT_W'(cur_row);
            want.top_row = ROW_OUT_W'(top_row);
            owed_q.push_back(want);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("[%0t] result %0d: %s got 'h%0h, expected 'h%0h",
                         $time, results_seen, what, got, want);
        endtask

        // Compare one returned status against the oldest owed one, field by field.
        task check_result(console_res_t got);
            console_res_t want;
            results_seen++;
            if (owed_q.size() == 0) begin
                report("result with no request outstanding", got, 0);
                return;
            end
            want = owed_q.pop_front();
            if (got.cur_col !== want.cur_col) report("cursor_col_out", got.cur_col, want.cur_col);
            if (got.cur_row !== want.cur_row) report("cursor_row_out", got.cur_row, want.cur_row);
            if (got.top_row !== want.top_row) report("top_row_out", got.top_row, want.top_row);
            if (got.code !== want.code) report("cell_code_out", got.code, want.code);
            if (got.dirty !== want.dirty) report("cell_dirty_out", got.dirty, want.dirty);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcce_req_if req_bus ();
    tcce_res_if res_bus ();

    console_scoreboard sb;
    int unsigned       idle_cycles = 0;
    int unsigned       burst_left = 0;
    int unsigned       stall_left = 0;
    bit                stall_mode = 1'b1;

    text_console_cell_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock.
    always #6 clk = ~clk;

    // Both channels are observed at the rising edge; the idle counter feeds the watchdog.
    always @(posedge clk)
    begin
        console_res_t got;
        if (rst_n) begin
            if (req_bus.valid && req_bus.ready)
                sb.note_request({req_bus.req_type, req_bus.char_code, req_bus.key_release,
                                 req_bus.cell_row, req_bus.cell_col});
            if (res_bus.valid && res_bus.ready) begin
                got = {res_bus.cursor_col_out, res_bus.cursor_row_out, res_bus.top_row_out,
                       res_bus.cell_code_out, res_bus.cell_dirty_out};
                sb.check_result(got);
            end
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Result side back-pressure: random stalls, switched off now and then for clean stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            res_bus.ready <= 1'b0;
            stall_left--;
        end
        else begin
            res_bus.ready <= 1'b1;
            if (stall_mode && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
        end
        if ($urandom_range(0, 149) == 0) stall_mode = !stall_mode;
    end

    // Watchdog: too long with nothing moving on either channel ends the run.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic console_req_t make_request(logic [REQ_TYPE_W-1:0] kind,
                                                  logic [CODE_W-1:0] code, logic key_up,
                                                  logic [CELL_ROW_W-1:0] row,
                                                  logic [CELL_COL_W-1:0] col);
        console_req_t it;
        it.kind   = kind;
        it.code   = code;
        it.key_up = key_up;
        it.row    = row;
        it.col    = col;
        return it;
    endfunction

    // Mostly text with control characters, reads mostly aimed inside the window, some cursor
    // traffic, rare clears and unused request codes. Unused fields carry random bits.
    function automatic console_req_t random_request();
        console_req_t it;
        int unsigned  pick;
        it = make_request(REQ_PUT, CODE_W'($urandom_range(32'h21, 32'h7E)),
                          $urandom_range(0, 3) == 0, CELL_ROW_W'($urandom),
                          CELL_COL_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.code = CH_NEWLINE;
        end
        else if (pick < 17) begin
            it.code = CH_BACKSPACE;
        end
        else if (pick < 23) begin
            it.code = CH_TAB;
        end
        else if (pick < 33) begin
            it.code = CODE_W'($urandom);
        end
        else if (pick < 55) begin
            it.code = CODE_W'($urandom_range(32'h20, 32'h7E));
        end
        else if (pick < 75) begin
            it.kind = REQ_READ;
            if ($urandom_range(0, 4) != 0) begin
                it.row = CELL_ROW_W'($urandom_range(0, sb.win_rows() - 1));
                it.col = CELL_COL_W'($urandom_range(0, sb.win_cols() - 1));
            end
        end
        else if (pick < 85) begin
            it.kind = REQ_LEFT;
        end
        else if (pick < 95) begin
            it.kind = REQ_RIGHT;
        end
        else if (pick < 96) begin
            it.kind = REQ_CLEAR;
        end
        else begin
            it.kind = REQ_CLEAR + REQ_TYPE_W'($urandom_range(1, 3));
        end
        return it;
    endfunction

    // Present one item at the falling edge and hold it until accepted. Items go out in
    // bursts; between bursts the valid line drops for a random gap.
    task automatic send_request(console_req_t it);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge clk);
                req_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= it.kind;
        req_bus.char_code   <= it.code;
        req_bus.key_release <= it.key_up;
        req_bus.cell_row    <= it.row;
        req_bus.cell_col    <= it.col;
        burst_left--;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
    endtask

    // Stop sending and wait until every owed result has been returned.
    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
    endtask

    // New window only once the engine is quiet, including any scroll or sweep still running.
    task automatic set_window(logic [7:0] cols, logic [7:0] rows);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_COLS, cols);
        write_register(CFG_ROWS, rows);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_COLS;
        cfg_data            = '0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_PUT;
        req_bus.char_code   = '0;
        req_bus.key_release = 1'b0;
        req_bus.cell_row    = '0;
        req_bus.cell_col    = '0;
        res_bus.ready       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening in the reset window of 80 by 25.
        send_request(make_request(REQ_PUT, 21'h41, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_PUT, 21'h1FFFFF, 1'b1, 6'd63, 7'd127));
        send_request(make_request(REQ_PUT, 21'h10FFFF, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_PUT, 21'h000000, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd0, 7'd1));
        send_request(make_request(REQ_PUT, CH_TAB, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_PUT, CH_NEWLINE, 1'b0, 6'd0, 7'd0));
        // Backspace at a line start wraps to the end of the previous line.
        send_request(make_request(REQ_PUT, CH_BACKSPACE, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd0, 7'd79));
        send_request(make_request(REQ_LEFT, '0, 1'b1, 6'd0, 7'd0));
        send_request(make_request(REQ_RIGHT, '0, 1'b1, 6'd0, 7'd0));
        send_request(make_request(REQ_LEFT, '0, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_RIGHT, '0, 1'b0, 6'd0, 7'd0));
        // Reads just past the window edges and at the field limits.
        send_request(make_request(REQ_READ, '0, 1'b1, 6'd63, 7'd127));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd24, 7'd80));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd25, 7'd0));
        send_request(make_request(REQ_CLEAR + 3'd1, 21'h1FFFFF, 1'b1, 6'd63, 7'd127));
        send_request(make_request(REQ_CLEAR + 3'd2, '0, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_CLEAR + 3'd3, 21'h0ABCDE, 1'b0, 6'd5, 7'd9));
        send_request(make_request(REQ_CLEAR, '0, 1'b0, 6'd0, 7'd0));
        // At the origin: backspace only blanks, cursor left does not move.
        send_request(make_request(REQ_PUT, CH_BACKSPACE, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_LEFT, '0, 1'b0, 6'd0, 7'd0));
        send_request(make_request(REQ_READ, '0, 1'b0, 6'd0, 7'd0));

        // Random phases, each in its own window; now and then the sender waits for all results.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_window(PHASE_COLS[8*ph +: 8], PHASE_ROWS[8*ph +: 8]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 49) == 0) wait_drained();
                send_request(random_request());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0) sb.report("results never returned", sb.pending(), 0);

        $display("Covered %0d puts, %0d reads, %0d cursor moves, %0d clears, %0d unused codes",
                 sb.kind_count[REQ_PUT], sb.kind_count[REQ_READ],
                 sb.kind_count[REQ_LEFT] + sb.kind_count[REQ_RIGHT], sb.kind_count[REQ_CLEAR],
                 sb.kind_count[5] + sb.kind_count[6] + sb.kind_count[7]);
        $display("over %0d window settings with %0d scrolls; %0d results checked, %0d mismatches",
                 NUM_PHASES + 1, sb.scrolls, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- text_console_cell_engine.f -----
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ifs.sv
hw/rtl/tcce_cell_store.sv
hw/rtl/text_console_cell_engine.sv
bench/tb_top.sv
